// ----- rtl/krf_pkg.sv -----
package krf_pkg;

  localparam int POOL_DEPTH_DEF  = 64;
  localparam int NUM_SOURCES_DEF = 50;
  localparam int REQUESTER_IDS   = 256;

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_CANCEL  = 2'd1;
  localparam logic [1:0] CMD_SERVICE = 2'd2;

  typedef struct packed {
    logic [7:0]  requester;
    logic [15:0] selection;
    logic [31:0] params;
    logic [5:0]  source;
  } rec_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;
    logic load;
    rec_t rec;
  } cell_cmd_t;

  // Summary of the chain seen by the sequencer.
  typedef struct packed {
    logic       hit;
    logic [5:0] hit_source;
    logic       front_valid;
    rec_t       front;
  } chain_stat_t;

endpackage

// ----- rtl/krf_cell.sv -----
module krf_cell #(
  parameter int POOL_DEPTH = krf_pkg::POOL_DEPTH_DEF,
  parameter int IDX        = 0,
  localparam int PW        = $clog2(POOL_DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  krf_pkg::cell_cmd_t  cmd,
  input  logic [PW-1:0]       shift_from,
  input  logic [PW-1:0]       load_at,
  input  logic [7:0]          key,
  input  logic                nb_valid,
  input  krf_pkg::rec_t       nb_rec,
  output logic                valid,
  output krf_pkg::rec_t       rec,
  output logic                match
);
  import krf_pkg::*;

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic do_load;
  logic do_shift;

  assign do_load  = cmd.load && (load_at == MY_IDX);
  // Every cell at or behind the removed position takes its neighbour's record.
  assign do_shift = cmd.shift && (MY_IDX >= shift_from);
  assign match    = valid && (rec.requester == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (do_load) begin
      valid <= 1'b1;
    end else if (do_shift) begin
      valid <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      rec <= cmd.rec;
    end else if (do_shift) begin
      rec <= nb_rec;
    end
  end

endmodule

// ----- rtl/krf_chain.sv -----
module krf_chain #(
  parameter int POOL_DEPTH = krf_pkg::POOL_DEPTH_DEF,
  localparam int PW        = $clog2(POOL_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  krf_pkg::cell_cmd_t    cmd,
  input  logic [PW-1:0]         shift_from,
  input  logic [PW-1:0]         load_at,
  input  logic [7:0]            key,
  output krf_pkg::chain_stat_t  stat,
  output logic [PW-1:0]         hit_pos
);
  import krf_pkg::*;

  logic [POOL_DEPTH-1:0] valid_v;
  logic [POOL_DEPTH-1:0] match_v;
  logic [POOL_DEPTH-1:0] nb_valid_v;
  rec_t                  rec_v    [POOL_DEPTH];
  rec_t                  nb_rec_v [POOL_DEPTH];
  logic [5:0]            hit_src;

  for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
    if (g == POOL_DEPTH - 1) begin : g_last
      assign nb_valid_v[g] = 1'b0;
      assign nb_rec_v[g]   = '0;
    end else begin : g_mid
      assign nb_valid_v[g] = valid_v[g+1];
      assign nb_rec_v[g]   = rec_v[g+1];
    end

    krf_cell #(
      .POOL_DEPTH (POOL_DEPTH),
      .IDX        (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .shift_from (shift_from),
      .load_at    (load_at),
      .key        (key),
      .nb_valid   (nb_valid_v[g]),
      .nb_rec     (nb_rec_v[g]),
      .valid      (valid_v[g]),
      .rec        (rec_v[g]),
      .match      (match_v[g])
    );
  end

  // A requester has at most one record queued, so the match is one-hot and
  // an OR of the gated values encodes it.
  always_comb begin
    hit_pos = '0;
    hit_src = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (match_v[i]) begin
        hit_pos = hit_pos | PW'(i);
        hit_src = hit_src | rec_v[i].source;
      end
    end
  end

  assign stat.hit         = |match_v;
  assign stat.hit_source  = hit_src;
  assign stat.front_valid = valid_v[0];
  assign stat.front       = rec_v[0];

endmodule

// ----- rtl/krf_tally.sv -----
module krf_tally #(
  parameter int POOL_DEPTH  = krf_pkg::POOL_DEPTH_DEF,
  parameter int NUM_SOURCES = krf_pkg::NUM_SOURCES_DEF,
  localparam int CW         = $clog2(POOL_DEPTH + 1),
  localparam int SAW        = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           rd_a_en,
  input  logic [SAW-1:0] rd_a_addr,
  output logic [CW-1:0]  rd_a_data,
  input  logic           rd_b_en,
  input  logic [SAW-1:0] rd_b_addr,
  output logic [CW-1:0]  rd_b_data,
  input  logic           wr_en,
  input  logic [SAW-1:0] wr_addr,
  input  logic [CW-1:0]  wr_data
);

  logic [CW-1:0]          mem [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] written;

  // An entry not written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_data <= written[rd_a_addr] ? mem[rd_a_addr] : '0;
    end
    if (rd_b_en) begin
      rd_b_data <= written[rd_b_addr] ? mem[rd_b_addr] : '0;
    end
  end

endmodule

// ----- rtl/keyed_request_fifo_unit.sv -----
// Each command runs through a match across the cell chain, a shift or load of
// the cells with the first write of the per-source tally memory, and a second
// write of that memory; a new command is taken only in the idle state, once the
// last result is posted, and posting waits while the previous result is not taken.
// Reset clears the cell valid bits, counters and tally valid bits at once;
// commands are taken as soon as reset is released.
module keyed_request_fifo_unit #(
  parameter int POOL_DEPTH  = krf_pkg::POOL_DEPTH_DEF,
  parameter int NUM_SOURCES = krf_pkg::NUM_SOURCES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  requester_id,
  input  logic [15:0] selection_index,
  input  logic [31:0] move_params,
  input  logic [5:0]  source_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        popped_valid,
  output logic [7:0]  popped_requester,
  output logic [15:0] popped_selection,
  output logic [31:0] popped_params,
  output logic [5:0]  popped_source,
  output logic        replaced_or_removed,
  output logic        full_error,
  output logic [6:0]  pending_count,
  output logic [6:0]  peak_count,
  output logic [6:0]  source_tally
);
  import krf_pkg::*;

  localparam int PW  = $clog2(POOL_DEPTH);
  localparam int CW  = $clog2(POOL_DEPTH + 1);
  localparam int SAW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_SHIFT,
    S_DEC,
    S_HOLD
  } state_t;

  state_t        state;

  logic [1:0]    cmd_q;
  logic [7:0]    who_q;
  logic [15:0]   sel_q;
  logic [31:0]   prm_q;
  logic [5:0]    src_q;

  logic          hit_q;
  logic [PW-1:0] pos_q;
  logic [5:0]    rsrc_q;
  rec_t          pop_q;
  logic          popv_q;
  logic          rem_q;
  logic          full_q;
  logic [CW-1:0] tally_q;
  logic [CW-1:0] count;
  logic [CW-1:0] peak;

  cell_cmd_t     chain_cmd;
  chain_stat_t   stat;
  logic [PW-1:0] hit_pos;

  logic          m_hit;
  logic [PW-1:0] m_pos;
  logic [5:0]    m_src;
  rec_t          m_pop;

  logic          who_ok;
  logic          src_ok;
  logic          rsrc_ok;
  logic          is_enq;
  logic          enq_ok;
  logic          same_src;
  logic [CW-1:0] cnt_rm;
  logic [CW-1:0] cnt_new;
  logic [CW-1:0] peak_new;
  logic [CW-1:0] tally_new;
  logic [CW-1:0] rd_a;
  logic [CW-1:0] rd_b;
  logic          post;

  logic           wr_en;
  logic [SAW-1:0] wr_addr;
  logic [CW-1:0]  wr_data;

  assign in_ready = (state == S_IDLE);
  assign post     = !out_valid || out_ready;

  assign who_ok   = int'(who_q) < REQUESTER_IDS;
  assign src_ok   = int'(src_q) < NUM_SOURCES;
  assign rsrc_ok  = int'(rsrc_q) < NUM_SOURCES;
  assign is_enq   = (cmd_q == CMD_ENQUEUE) && who_ok;
  assign same_src = hit_q && (rsrc_q == src_q);

  assign cnt_rm    = count - CW'(hit_q);
  assign enq_ok    = is_enq && (cnt_rm < CW'(POOL_DEPTH));
  assign cnt_new   = cnt_rm + CW'(enq_ok);
  assign peak_new  = (cnt_new > peak) ? cnt_new : peak;
  assign tally_new = rd_a + CW'(enq_ok) - CW'(same_src);

  // Chain lookup result, chosen by command.
  always_comb begin
    m_hit = 1'b0;
    m_pos = hit_pos;
    m_src = stat.hit_source;
    m_pop = '0;
    case (cmd_q)
      CMD_ENQUEUE, CMD_CANCEL: begin
        m_hit = who_ok && stat.hit;
      end
      CMD_SERVICE: begin
        m_hit = stat.front_valid;
        m_pos = '0;
        m_src = stat.front.source;
        if (stat.front_valid) begin
          m_pop = stat.front;
        end
      end
      default: begin
        m_hit = 1'b0;
      end
    endcase
  end

  assign chain_cmd.shift = (state == S_SHIFT) && hit_q;
  assign chain_cmd.load  = (state == S_SHIFT) && enq_ok;
  assign chain_cmd.rec   = '{requester: who_q, selection: sel_q, params: prm_q,
                             source: src_q};

  krf_chain #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .cmd        (chain_cmd),
    .shift_from (pos_q),
    .load_at    (cnt_rm[PW-1:0]),
    .key        (who_q),
    .stat       (stat),
    .hit_pos    (hit_pos)
  );

  // The item's own source is updated first; a removed record of another
  // source is decremented in the cycle after, from the second read port.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = SAW'(src_q);
    wr_data = tally_new;
    if (state == S_SHIFT) begin
      wr_en = src_ok && (enq_ok || same_src);
    end else if (state == S_DEC) begin
      wr_en   = hit_q && rsrc_ok && !same_src;
      wr_addr = SAW'(rsrc_q);
      wr_data = rd_b - CW'(1);
    end
  end

  krf_tally #(
    .POOL_DEPTH  (POOL_DEPTH),
    .NUM_SOURCES (NUM_SOURCES)
  ) u_tally (
    .clk       (clk),
    .rst       (rst),
    .rd_a_en   (in_valid && in_ready),
    .rd_a_addr (SAW'(source_id)),
    .rd_a_data (rd_a),
    .rd_b_en   (state == S_SHIFT),
    .rd_b_addr (SAW'(rsrc_q)),
    .rd_b_data (rd_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      peak      <= '0;
    end else begin
      // A result taken while the next one is being posted is replaced below.
      if (out_valid && out_ready && !(state inside {S_DEC, S_HOLD})) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q <= command;
            who_q <= requester_id;
            sel_q <= selection_index;
            prm_q <= move_params;
            src_q <= source_id;
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          hit_q  <= m_hit;
          pos_q  <= m_pos;
          rsrc_q <= m_src;
          pop_q  <= m_pop;
          popv_q <= m_hit && (cmd_q == CMD_SERVICE);
          rem_q  <= m_hit && (cmd_q != CMD_SERVICE);
          state  <= S_SHIFT;
        end
        S_SHIFT: begin
          count   <= cnt_new;
          peak    <= peak_new;
          full_q  <= is_enq && !enq_ok;
          tally_q <= src_ok ? tally_new : '0;
          state   <= S_DEC;
        end
        S_DEC, S_HOLD: begin
          if (post) begin
            out_valid           <= 1'b1;
            popped_valid        <= popv_q;
            popped_requester    <= pop_q.requester;
            popped_selection    <= pop_q.selection;
            popped_params       <= pop_q.params;
            popped_source       <= pop_q.source;
            replaced_or_removed <= rem_q;
            full_error          <= full_q;
            pending_count       <= 7'(count);
            peak_count          <= 7'(peak);
            source_tally        <= 7'(tally_q);
            state               <= S_IDLE;
          end else begin
            state <= S_HOLD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
